### rtl/rxep_pkg.sv
// ----------------------------------------------------------------------------
// rxep_pkg
// Shared types and constants for the run-length XOR entropy pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rxep_pkg;

  // Default pool depth in bytes (legal range 16 to 255).
  localparam int POOL_BYTES_DEF = 64;

  // Pool addresses travel at the width that the largest pool needs.
  localparam int ADDR_W = 8;

  // Pool XOR operations one message byte can cause.
  localparam int NOPS = 4;
  localparam int OP_RUN_VALUE = 0;
  localparam int OP_RUN_COUNT = 1;
  localparam int OP_FIN_VALUE = 2;
  localparam int OP_FIN_COUNT = 3;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [9:0]  MIN_POOL = 10'd16;
  localparam logic [11:0] RATE_MAX = 12'd2048;
  localparam logic [15:0] RUNS_MAX = 16'hFFFF;

  localparam logic [ADDR_W-1:0] SLOT_FIN_VALUE = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SLOT_FIN_COUNT = ADDR_W'(1);

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [11:0] rate_q8;
    logic [5:0]  read_index;
  } rxep_in_t;

  typedef struct packed {
    logic [7:0] pool_byte;
    logic [8:0] remaining_bits;
    logic       goal_reached;
  } rxep_out_t;

  // One classified word: the pool XORs it needs and the result it reports.
  // For a read, op_addr[OP_RUN_VALUE] holds the read address.
  typedef struct packed {
    logic [NOPS-1:0][ADDR_W-1:0] op_addr;
    logic [NOPS-1:0][7:0]        op_val;
    logic [NOPS-1:0]             op_en;
    logic                        rd_en;
    logic [8:0]                  remaining_bits;
    logic                        goal_reached;
  } rxep_cmd_t;

endpackage

`default_nettype wire

### rtl/rxep_front.sv
// ----------------------------------------------------------------------------
// rxep_front
// Accepts words, tracks the run-length state and the credit, and turns each
// word into a command of pool XOR operations for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rxep_front #(
  parameter int POOL_BYTES = rxep_pkg::POOL_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rxep_pkg::rxep_in_t  in_item,
  input  wire logic                cfg_we,
  input  wire logic [8:0]          cfg_data,
  input  wire logic                q_full,
  output logic                     q_push,
  output rxep_pkg::rxep_cmd_t      q_cmd
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int SW = $clog2(POOL_BYTES + 1);
  localparam int CW = $clog2(8 * POOL_BYTES + 1);
  localparam int AD = rxep_pkg::ADDR_W;

  logic [8:0]    goal_r,  goal_nxt;
  logic [SW-1:0] size_r,  size_nxt;
  logic [CW-1:0] cred_r,  cred_nxt;
  logic [AW-1:0] wi_r,    wi_nxt;
  logic [7:0]    rv_r,    rv_nxt;
  logic [7:0]    rc_r,    rc_nxt;
  logic [15:0]   runs_r,  runs_nxt;

  logic          accept;
  logic          change;
  logic          cnt_op;
  logic [AW-1:0] wi_a1, wi_a2;
  logic [7:0]    rv_n, rc_n;
  logic [15:0]   runs_n;
  logic [11:0]   rate_c;
  logic [27:0]   prod;
  logic [20:0]   sum, cap;
  logic [CW-1:0] cred_fin, cred_out;
  logic [12:0]   diff;
  logic          reached;
  logic [9:0]    sz_q;
  logic          rd_ok;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] w, input logic [SW-1:0] s);
    logic [SW:0] n;
    n = (SW+1)'(w) + (SW+1)'(1);
    return (n >= (SW+1)'(s)) ? '0 : n[AW-1:0];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    change = (in_item.data_byte != rv_r);
    cnt_op = change && (rc_r > 8'd1);
    wi_a1  = change ? adv(wi_r, size_r) : wi_r;
    wi_a2  = cnt_op ? adv(wi_a1, size_r) : wi_a1;
    rv_n   = change ? in_item.data_byte : rv_r;
    rc_n   = change ? 8'd1 : rc_r + 8'd1;
    if (change && (runs_r != rxep_pkg::RUNS_MAX)) begin
      runs_n = runs_r + 16'd1;
    end else begin
      runs_n = runs_r;
    end

    rate_c   = (in_item.rate_q8 > rxep_pkg::RATE_MAX) ? rxep_pkg::RATE_MAX : in_item.rate_q8;
    prod     = 28'(rate_c) * 28'(runs_n);
    sum      = 21'(cred_r) + 21'(prod[27:8]);
    cap      = 21'({size_r, 3'b000});
    cred_fin = (sum > cap) ? CW'(cap) : CW'(sum);

    if ((in_item.mode == rxep_pkg::MODE_ADD) && in_item.last_byte) begin
      cred_out = cred_fin;
    end else begin
      cred_out = cred_r;
    end
    reached = (13'(cred_out) >= 13'(goal_r));
    diff    = 13'(goal_r) - 13'(cred_out);

    rd_ok = (9'(in_item.read_index) < 9'(POOL_BYTES));

    q_cmd                = '0;
    q_cmd.goal_reached   = reached;
    q_cmd.remaining_bits = reached ? 9'd0 : diff[8:0];
    if (in_item.mode == rxep_pkg::MODE_READ) begin
      q_cmd.op_addr[rxep_pkg::OP_RUN_VALUE] = AD'(in_item.read_index);
      q_cmd.rd_en = rd_ok;
    end else begin
      // XOR with zero leaves the pool as it is, so such operations are dropped.
      q_cmd.op_addr[rxep_pkg::OP_RUN_VALUE] = AD'(wi_r);
      q_cmd.op_val[rxep_pkg::OP_RUN_VALUE]  = rv_r;
      q_cmd.op_en[rxep_pkg::OP_RUN_VALUE]   = change && (rv_r != 8'd0);
      q_cmd.op_addr[rxep_pkg::OP_RUN_COUNT] = AD'(wi_a1);
      q_cmd.op_val[rxep_pkg::OP_RUN_COUNT]  = rc_r;
      q_cmd.op_en[rxep_pkg::OP_RUN_COUNT]   = cnt_op;
      q_cmd.op_addr[rxep_pkg::OP_FIN_VALUE] = rxep_pkg::SLOT_FIN_VALUE;
      q_cmd.op_val[rxep_pkg::OP_FIN_VALUE]  = rv_n;
      q_cmd.op_en[rxep_pkg::OP_FIN_VALUE]   = in_item.last_byte && (rv_n != 8'd0);
      q_cmd.op_addr[rxep_pkg::OP_FIN_COUNT] = rxep_pkg::SLOT_FIN_COUNT;
      q_cmd.op_val[rxep_pkg::OP_FIN_COUNT]  = rc_n;
      q_cmd.op_en[rxep_pkg::OP_FIN_COUNT]   = in_item.last_byte && (rc_n != 8'd0);
    end
  end

  always_comb begin
    goal_nxt = goal_r;
    size_nxt = size_r;
    cred_nxt = cred_r;
    wi_nxt   = wi_r;
    rv_nxt   = rv_r;
    rc_nxt   = rc_r;
    runs_nxt = runs_r;
    sz_q     = {3'b000, cfg_data[8:2]};
    if (cfg_we) begin
      goal_nxt = cfg_data;
      if (sz_q < rxep_pkg::MIN_POOL) begin
        sz_q = rxep_pkg::MIN_POOL;
      end
      if (sz_q > 10'(POOL_BYTES)) begin
        sz_q = 10'(POOL_BYTES);
      end
      size_nxt = sz_q[SW-1:0];
      cred_nxt = '0;
      wi_nxt   = '0;
      rv_nxt   = 8'd0;
      rc_nxt   = 8'd0;
      runs_nxt = 16'd0;
    end else if (accept && (in_item.mode == rxep_pkg::MODE_ADD)) begin
      if (in_item.last_byte) begin
        cred_nxt = cred_fin;
        wi_nxt   = '0;
        rv_nxt   = 8'd0;
        rc_nxt   = 8'd0;
        runs_nxt = 16'd0;
      end else begin
        wi_nxt   = wi_a2;
        rv_nxt   = rv_n;
        rc_nxt   = rc_n;
        runs_nxt = runs_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= 9'd0;
      size_r <= SW'(rxep_pkg::MIN_POOL);
      cred_r <= '0;
      wi_r   <= '0;
      rv_r   <= 8'd0;
      rc_r   <= 8'd0;
      runs_r <= 16'd0;
    end else begin
      goal_r <= goal_nxt;
      size_r <= size_nxt;
      cred_r <= cred_nxt;
      wi_r   <= wi_nxt;
      rv_r   <= rv_nxt;
      rc_r   <= rc_nxt;
      runs_r <= runs_nxt;
    end
  end

`ifndef SYNTHESIS
  a_wi_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    wi_r < size_r)
    else $error("write index outside the active pool");
  a_cred_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= {size_r, 3'b000})
    else $error("credit above eight bits per pool byte");
`endif

endmodule

`default_nettype wire

### rtl/rxep_queue.sv
// ----------------------------------------------------------------------------
// rxep_queue
// Small command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rxep_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire rxep_pkg::rxep_cmd_t  push_cmd,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output rxep_pkg::rxep_cmd_t       head_cmd
);

  localparam int D  = rxep_pkg::CMDQ_DEPTH;
  localparam int PW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  rxep_pkg::rxep_cmd_t mem_r [D];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == NW'(D));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue written while full");
`endif

endmodule

`default_nettype wire

### rtl/rxep_back.sv
// ----------------------------------------------------------------------------
// rxep_back
// Holds the pool memory and carries out one read-modify-write XOR per cycle
// unless stalled for result room, then queues the result word of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module rxep_back #(
  parameter int POOL_BYTES = rxep_pkg::POOL_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clear,
  input  wire logic                 q_valid,
  input  wire rxep_pkg::rxep_cmd_t  q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rxep_pkg::rxep_out_t       out_item
);

  localparam int AW  = $clog2(POOL_BYTES);
  localparam int NO  = rxep_pkg::NOPS;
  localparam int OW  = $clog2(NO);
  localparam int OD  = rxep_pkg::OUTQ_DEPTH;
  localparam int OPW = $clog2(OD);
  localparam int OCW = $clog2(OD + 1);

  // Pool storage; an entry whose valid bit is clear reads as zero.
  logic [7:0]            mem [POOL_BYTES];
  logic [POOL_BYTES-1:0] vld_r;

  logic [NO-1:0] done_r, done_nxt;
  logic [NO-1:0] pending, low;
  logic [OW-1:0] sel;
  logic          last_op, space_ok, issue;
  logic [AW-1:0] iss_addr;

  logic          s1_v_r, s1_we_r, s1_emit_r, s1_rd_r, s1_reach_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    s1_val_r;
  logic [8:0]    s1_rem_r;
  logic [7:0]    rd_r;
  logic          rdv_r;
  logic          wb_v_r;
  logic [AW-1:0] wb_addr_r;
  logic [7:0]    wb_data_r;
  logic [7:0]    old_byte, new_byte;
  logic          s1_write;

  rxep_pkg::rxep_out_t obuf_r [OD];
  logic [OPW-1:0] owp_r, owp_nxt;
  logic [OPW-1:0] orp_r, orp_nxt;
  logic [OCW-1:0] ocnt_r, ocnt_nxt;
  logic           opush, opop;

  // Pick the lowest outstanding operation of the head command.
  always_comb begin
    pending = q_cmd.op_en & ~done_r;
    low     = pending & (~pending + NO'(1));
    last_op = ((pending & ~low) == '0);
    sel     = '0;
    for (int i = NO - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = OW'(i);
      end
    end
    iss_addr = q_cmd.op_addr[sel][AW-1:0];
    // The final step of a command yields a result, so it needs a free output slot.
    space_ok = ((ocnt_r + OCW'(s1_v_r && s1_emit_r)) < OCW'(OD));
    issue    = q_valid && (!last_op || space_ok);
    q_pop    = issue && last_op;
    if (q_pop) begin
      done_nxt = '0;
    end else if (issue) begin
      done_nxt = done_r | low;
    end else begin
      done_nxt = done_r;
    end
  end

  // A write made in the previous cycle is not yet in the read data.
  always_comb begin
    if (wb_v_r && (wb_addr_r == s1_addr_r)) begin
      old_byte = wb_data_r;
    end else begin
      old_byte = rdv_r ? rd_r : 8'd0;
    end
    new_byte = old_byte ^ s1_val_r;
    s1_write = s1_v_r && s1_we_r;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_r  <= mem[iss_addr];
      rdv_r <= vld_r[iss_addr];
    end
    if (s1_write) begin
      mem[s1_addr_r] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (s1_write) begin
      vld_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_we_r    <= (pending != '0);
    s1_addr_r  <= iss_addr;
    s1_val_r   <= q_cmd.op_val[sel];
    s1_emit_r  <= last_op;
    s1_rd_r    <= q_cmd.rd_en;
    s1_rem_r   <= q_cmd.remaining_bits;
    s1_reach_r <= q_cmd.goal_reached;
    wb_addr_r  <= s1_addr_r;
    wb_data_r  <= new_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      s1_v_r <= issue;
      wb_v_r <= s1_write;
    end
  end

  // Result FIFO.
  assign opush     = s1_v_r && s1_emit_r;
  assign out_valid = (ocnt_r != '0);
  assign opop      = out_valid && out_ready;
  assign out_item  = obuf_r[orp_r];

  always_comb begin
    owp_nxt  = opush ? owp_r + OPW'(1) : owp_r;
    orp_nxt  = opop ? orp_r + OPW'(1) : orp_r;
    ocnt_nxt = ocnt_r + OCW'(opush) - OCW'(opop);
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf_r[owp_r].pool_byte      <= s1_rd_r ? old_byte : 8'd0;
      obuf_r[owp_r].remaining_bits <= s1_rem_r;
      obuf_r[owp_r].goal_reached   <= s1_reach_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    opush |-> ((ocnt_r != OCW'(OD)) || opop))
    else $error("result FIFO written while full");
  a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ((done_r & ~q_cmd.op_en) == '0))
    else $error("completed operation not part of the head command");
`endif

endmodule

`default_nettype wire

### rtl/rle_xor_entropy_pool_top.sv
// ----------------------------------------------------------------------------
// rle_xor_entropy_pool_top
// Run-length XOR entropy pool with byte read-back and entropy credit.
// ----------------------------------------------------------------------------
// A new word is taken every cycle while the four-entry command queue has room;
// the front end does the run-length bookkeeping and the credit update in the
// cycle it accepts a word. The back end makes one XOR into the pool memory per
// cycle, but a command's final step waits for room in the result FIFO. A word
// causes up to four nonzero pool XORs: none for a read or for a byte that
// continues a run, up to two for a byte that ends one, and up to four for a
// final byte; its result is registered in the back end before it is queued.
// Writing the goal register clears the pool at once through per-entry valid
// bits and must be done while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_xor_entropy_pool_top #(
  parameter int POOL_BYTES = rxep_pkg::POOL_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rxep_pkg::rxep_in_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rxep_pkg::rxep_out_t       out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [8:0]           cfg_data
);

  logic                cfg_we;
  logic                q_full, q_push, q_pop, q_valid;
  rxep_pkg::rxep_cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  rxep_front #(
    .POOL_BYTES(POOL_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rxep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  rxep_back #(
    .POOL_BYTES(POOL_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rle_xor_entropy_pool_top. A driver and a monitor run
// as clocked blocks around a cycle-free prediction of the run-length pool,
// credit and read-back. Directed messages come first, then random messages
// under several goal settings and a message whose runs wrap the run counter.
// ----------------------------------------------------------------------------
module tb;

  localparam int POOL_N        = rxep_pkg::POOL_BYTES_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_WORDS   = 65;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rxep_pkg::rxep_in_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rxep_pkg::rxep_out_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [8:0]          cfg_data = '0;

  rle_xor_entropy_pool_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state.
  logic [7:0]  pool_img [POOL_N];
  int unsigned wr_pos;
  int unsigned pool_len;
  int unsigned run_total;
  int unsigned credit;
  int unsigned goal_val;
  logic [7:0]  cur_val;
  logic [7:0]  cur_cnt;

  rxep_pkg::rxep_in_t  pending_words [$];
  rxep_pkg::rxep_out_t expected_results [$];

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int          hold_req = 0;
  int          hold_seen = 0;
  logic [8:0]  goal_req_val = '0;
  int          goal_req_cnt = 0;
  int          goal_writes_done = 0;
  rxep_pkg::rxep_out_t want;

  function automatic void forget_message();
    wr_pos    = 0;
    cur_val   = '0;
    cur_cnt   = '0;
    run_total = 0;
  endfunction

  function automatic void load_goal(input logic [8:0] g);
    int unsigned sz;
    sz = g / 4;
    if (sz < rxep_pkg::MIN_POOL) sz = rxep_pkg::MIN_POOL;
    if (sz > POOL_N) sz = POOL_N;
    goal_val = g;
    pool_len = sz;
    for (int i = 0; i < POOL_N; i++) pool_img[i] = '0;
    credit = 0;
    forget_message();
  endfunction

  function automatic void pool_xor_step(input logic [7:0] v);
    pool_img[wr_pos] ^= v;
    wr_pos = (wr_pos + 1 >= pool_len) ? 0 : wr_pos + 1;
  endfunction

  function automatic rxep_pkg::rxep_out_t absorb_word(input rxep_pkg::rxep_in_t w);
    rxep_pkg::rxep_out_t r;
    int unsigned         rate;
    int unsigned         total;
    r = '0;
    if (w.mode == rxep_pkg::MODE_READ) begin
      if (w.read_index < POOL_N) r.pool_byte = pool_img[w.read_index];
    end else begin
      if (w.data_byte != cur_val) begin
        pool_xor_step(cur_val);
        if (cur_cnt > 8'd1) pool_xor_step(cur_cnt);
        if (run_total < rxep_pkg::RUNS_MAX) run_total++;
        cur_val = w.data_byte;
        cur_cnt = 8'd1;
      end else begin
        cur_cnt = cur_cnt + 8'd1;
      end
      if (w.last_byte) begin
        pool_img[rxep_pkg::SLOT_FIN_VALUE] ^= cur_val;
        pool_img[rxep_pkg::SLOT_FIN_COUNT] ^= cur_cnt;
        rate = (w.rate_q8 > rxep_pkg::RATE_MAX) ? rxep_pkg::RATE_MAX : w.rate_q8;
        total = credit + ((rate * run_total) >> 8);
        credit = (total > 8 * pool_len) ? 8 * pool_len : total;
        forget_message();
      end
    end
    if (credit >= goal_val) begin
      r.goal_reached = 1'b1;
    end else begin
      r.remaining_bits = 9'(goal_val - credit);
    end
    return r;
  endfunction

  // Sender: each word waits a drawn number of idle cycles before it is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(absorb_word(in_item));
        in_gap = in_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_item  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with none outstanding: %p", out_item);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.pool_byte !== want.pool_byte) begin
            $error("pool_byte: expected %0h, got %0h", want.pool_byte, out_item.pool_byte);
            mismatches++;
          end
          if (out_item.remaining_bits !== want.remaining_bits) begin
            $error("remaining_bits: expected %0d, got %0d",
                   want.remaining_bits, out_item.remaining_bits);
            mismatches++;
          end
          if (out_item.goal_reached !== want.goal_reached) begin
            $error("goal_reached: expected %0b, got %0b",
                   want.goal_reached, out_item.goal_reached);
            mismatches++;
          end
        end
        out_stall = out_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_stall = HOLD_CYCLES;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      load_goal(cfg_data);
      goal_writes_done++;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && goal_req_cnt != goal_writes_done) begin
      cfg_data  <= goal_req_val;
      cfg_valid <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL rle_xor_entropy_pool_top");
    $finish;
  end

  task automatic push_add(input logic [7:0] b, input logic lst, input logic [11:0] rate);
    rxep_pkg::rxep_in_t w;
    w.mode       = rxep_pkg::MODE_ADD;
    w.data_byte  = b;
    w.last_byte  = lst;
    w.rate_q8    = rate;
    w.read_index = 6'($urandom_range(0, 63));
    pending_words.push_back(w);
  endtask

  task automatic push_read(input logic [5:0] idx);
    rxep_pkg::rxep_in_t w;
    w.mode       = rxep_pkg::MODE_READ;
    w.data_byte  = 8'($urandom_range(0, 255));
    w.last_byte  = 1'($urandom_range(0, 1));
    w.rate_q8    = 12'($urandom_range(0, 4095));
    w.read_index = idx;
    pending_words.push_back(w);
  endtask

  // Waits until every offered word has produced its result, then lets the
  // back end finish its last pool writes.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_goal(input logic [8:0] g);
    settle();
    goal_req_val = g;
    goal_req_cnt++;
    while (goal_writes_done != goal_req_cnt) @(posedge clk);
  endtask

  // Mostly complete messages with runs and interleaved reads; sometimes the
  // tail is left open so that the following goal write abandons it.
  task automatic random_traffic(input int n_words);
    int         sent;
    int         len;
    int         tail;
    bit         narrow;
    logic [7:0] b;
    logic [11:0] rate;
    sent = 0;
    b = '0;
    while (sent < n_words) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      narrow = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          push_read(6'($urandom_range(0, 63)));
          sent++;
        end
        if ($urandom_range(0, 1) == 0)
          b = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        rate = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(2049, 4095))
                                           : 12'($urandom_range(0, 2048));
        push_add(b, k == len - 1, rate);
        sent++;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      tail = $urandom_range(1, 4);
      for (int k = 0; k < tail; k++)
        push_add(8'($urandom_range(0, 255)), 1'b0, 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    logic [8:0] g;
    load_goal('0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: goal zero and a sixteen-byte pool.
    push_read(6'd0);
    push_add(8'h00, 1'b1, 12'd2048);
    push_read(6'd1);

    write_goal(9'd40);
    push_add(8'h00, 1'b0, 12'd7);      // first byte equal to the idle run value
    push_add(8'hFF, 1'b0, 12'd0);
    push_add(8'hFF, 1'b0, 12'd0);
    push_add(8'hFF, 1'b0, 12'd0);
    push_read(6'd1);                   // read in the middle of a message
    push_add(8'h01, 1'b0, 12'd0);
    push_add(8'h80, 1'b0, 12'd0);
    push_add(8'h80, 1'b1, 12'hFFF);    // rate above 8.0 gets clamped
    push_read(6'd0);
    push_read(6'd1);
    push_read(6'd2);
    push_read(6'd63);
    push_add(8'hAA, 1'b1, 12'd0);      // one-byte message at zero rate
    push_add(8'h12, 1'b0, 12'd300);
    push_add(8'h13, 1'b0, 12'd300);    // left open for the next goal write

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: g = 9'd511;
        1: g = 9'd0;
        2: g = 9'd256;
        3: g = 9'd1;
        4: g = 9'd64;
        5: g = 9'd63;
        6: g = 9'd100;
        7: g = 9'd300;
        8: g = 9'd17;
        default: g = 9'($urandom_range(0, 511));
      endcase
      write_goal(g);
      in_idle_on  = (p % 3 != 2);
      out_idle_on = (p % 4 != 3);
      if (p == 2 || p == 7) begin
        // Receiver holds off while the sender keeps the input full.
        in_idle_on = 1'b0;
        hold_req++;
      end
      random_traffic(PHASE_WORDS);
    end

    // Runs that wrap the 8-bit run counter to 0 and to 1.
    write_goal(9'd511);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (256) push_add(8'h33, 1'b0, 12'd0);
    repeat (257) push_add(8'h77, 1'b0, 12'd0);
    push_add(8'h12, 1'b1, 12'd512);
    for (int k = 0; k < 6; k++) push_read(6'(k));

    settle();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASS rle_xor_entropy_pool_top");
    else
      $display("FAIL rle_xor_entropy_pool_top");
    $finish;
  end

endmodule
